### hdl/smp_pkg.sv
// ============================================================================
// smp_pkg
// Shared types and constants for the STUN message parser.
// ============================================================================
package smp_pkg;

    localparam logic [17:0] HDR_BYTES = 18'd20;
    localparam logic [15:0] XMA_TYPE  = 16'h0020;
    localparam logic [31:0] COOKIE    = 32'h2112_A442;
    localparam logic [7:0]  FAMILY_V4 = 8'h01;
    localparam logic [16:0] POS_MAX   = 17'h1_FFFF;

    // byte regions
    localparam logic [2:0] RG_TYPE    = 3'd0;
    localparam logic [2:0] RG_LENGTH  = 3'd1;
    localparam logic [2:0] RG_COOKIE  = 3'd2;
    localparam logic [2:0] RG_TID     = 3'd3;
    localparam logic [2:0] RG_AHDR    = 3'd4;
    localparam logic [2:0] RG_VALUE   = 3'd5;
    localparam logic [2:0] RG_PAD     = 3'd6;
    localparam logic [2:0] RG_IGNORED = 3'd7;

    // parse status
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT_HDR = 3'd1;
    localparam logic [2:0] ST_CUT_AHDR  = 3'd2;
    localparam logic [2:0] ST_OVERRUN   = 3'd3;
    localparam logic [2:0] ST_TOO_LONG  = 3'd4;
    localparam logic [2:0] ST_TOO_MANY  = 3'd5;

    // XOR-MAPPED-ADDRESS status
    localparam logic [1:0] XS_FOUND  = 2'd0;
    localparam logic [1:0] XS_ABSENT = 2'd1;
    localparam logic [1:0] XS_SHORT  = 2'd2;
    localparam logic [1:0] XS_FAMILY = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic [2:0]  region;
        logic [8:0]  region_offset;
        logic [3:0]  attr_index;
        logic [15:0] attr_kind;
        logic [15:0] attr_length;
        logic        done_res;
        logic [2:0]  status;
        logic [4:0]  attr_count;
        logic [1:0]  xaddr_status;
        logic [31:0] mapped_ip;
        logic [15:0] mapped_port;
    } res_t;

endpackage

### hdl/smp_in_reg.sv
// ============================================================================
// smp_in_reg
// Input register: captures one byte transaction, frees when the core advances.
// ============================================================================
module smp_in_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  smp_pkg::item_t s_item,
    input  logic          adv,
    output logic          in_vld,
    output smp_pkg::item_t in_item
);
    import smp_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;

    assign s_ready  = !vld_reg || adv;
    assign vld_next = s_ready ? s_valid : vld_reg;
    assign in_vld   = vld_reg;
    assign in_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

### hdl/smp_core.sv
// ============================================================================
// smp_core
// Parser state and per-byte tagging logic; one byte per step.
// ============================================================================
module smp_core #(
    parameter int MAX_ATTRS       = 16,
    parameter int MAX_VALUE_BYTES = 512
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           step,
    input  smp_pkg::item_t item,
    output smp_pkg::res_t  res
);
    import smp_pkg::*;

    localparam int AW = $clog2(MAX_ATTRS + 1);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_AHDR   = 3'd1;
    localparam logic [2:0] PH_VALUE  = 3'd2;
    localparam logic [2:0] PH_PAD    = 3'd3;
    localparam logic [2:0] PH_END    = 3'd4;

    logic [16:0]   pos_reg,   pos_next;
    logic [15:0]   mlen_reg,  mlen_next;
    logic [2:0]    phase_reg, phase_next;
    logic [15:0]   vrem_reg,  vrem_next;
    logic [1:0]    prem_reg,  prem_next;
    logic [AW-1:0] anum_reg,  anum_next;
    logic [15:0]   ctype_reg, ctype_next;
    logic [15:0]   clen_reg,  clen_next;
    logic [2:0]    err_reg,   err_next;
    logic [2:0]    perr_reg,  perr_next;
    logic [1:0]    xst_reg,   xst_next;
    logic          xseen_reg, xseen_next;
    logic [31:0]   ip_reg,    ip_next;
    logic [15:0]   port_reg,  port_next;
    logic [1:0]    hcnt_reg,  hcnt_next;
    logic [7:0]    fam_reg,   fam_next;

    logic [7:0]  b;
    logic        last;
    logic [17:0] after;
    logic [17:0] msg_end;
    logic [4:0]  pos5;
    logic [31:0] anum_ext;
    logic [31:0] anum_m1;
    logic [31:0] cnt_ext;
    logic [15:0] ty, le, voff, vdec;
    logic [2:0]  pe;
    logic [1:0]  padt, pdec;
    logic        do_accept, next_attr;

    always_comb begin
        b        = item.data_byte;
        last     = item.last_byte;
        after    = {1'b0, pos_reg} + 18'd1;
        msg_end  = HDR_BYTES + {2'b00, mlen_reg};
        pos5     = pos_reg[4:0];
        anum_ext = 32'(anum_reg);
        anum_m1  = anum_ext - 32'd1;

        pos_next   = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 17'd1;
        mlen_next  = mlen_reg;
        phase_next = phase_reg;
        vrem_next  = vrem_reg;
        prem_next  = prem_reg;
        anum_next  = anum_reg;
        ctype_next = ctype_reg;
        clen_next  = clen_reg;
        err_next   = err_reg;
        perr_next  = perr_reg;
        xst_next   = xst_reg;
        xseen_next = xseen_reg;
        ip_next    = ip_reg;
        port_next  = port_reg;
        hcnt_next  = hcnt_reg;
        fam_next   = fam_reg;

        ty        = 16'h0;
        le        = 16'h0;
        pe        = ST_OK;
        voff      = 16'h0;
        vdec      = 16'h0;
        padt      = 2'd0;
        pdec      = 2'd0;
        do_accept = 1'b0;
        next_attr = 1'b0;

        res               = '0;
        res.byte_value    = b;
        res.region        = RG_IGNORED;
        res.done_res      = last;

        case (phase_reg)
            PH_HEADER: begin
                if (pos5 < 5'd2) begin
                    res.region = RG_TYPE;
                    res.region_offset = 9'(pos5);
                end else if (pos5 < 5'd4) begin
                    res.region = RG_LENGTH;
                    res.region_offset = 9'(pos5 - 5'd2);
                end else if (pos5 < 5'd8) begin
                    res.region = RG_COOKIE;
                    res.region_offset = 9'(pos5 - 5'd4);
                end else begin
                    res.region = RG_TID;
                    res.region_offset = 9'(pos5 - 5'd8);
                end
                if (pos5 == 5'd2) mlen_next = {b, 8'h00};
                if (pos5 == 5'd3) mlen_next = {mlen_reg[15:8], b};
                if (pos5 >= 5'd19) begin
                    phase_next = (mlen_next == 16'h0) ? PH_END : PH_AHDR;
                    hcnt_next  = 2'd0;
                end else if (last) begin
                    err_next   = ST_SHORT_HDR;
                    phase_next = PH_END;
                end
            end
            PH_AHDR: begin
                res.region        = RG_AHDR;
                res.region_offset = 9'(hcnt_reg);
                res.attr_index    = anum_ext[3:0];
                if (hcnt_reg == 2'd0) begin
                    pe = (anum_ext >= 32'(MAX_ATTRS)) ? ST_TOO_MANY : ST_OK;
                end else begin
                    ty = ctype_reg;
                    le = clen_reg;
                    pe = perr_reg;
                end
                if (hcnt_reg < 2'd2) ty = {ty[7:0], b};
                else                 le = {le[7:0], b};
                ctype_next = ty;
                clen_next  = le;
                perr_next  = pe;
                if (hcnt_reg != 2'd3) begin
                    hcnt_next = hcnt_reg + 2'd1;
                    if (last || after >= msg_end) begin
                        err_next   = ST_CUT_AHDR;
                        phase_next = PH_END;
                    end
                end else begin
                    hcnt_next = 2'd0;
                    if (pe == ST_TOO_MANY) begin
                        err_next   = ST_TOO_MANY;
                        phase_next = PH_END;
                    end else if ({2'b00, le} + after > msg_end) begin
                        err_next   = ST_OVERRUN;
                        phase_next = PH_END;
                    end else begin
                        perr_next = ({16'h0, le} > 32'(MAX_VALUE_BYTES)) ? ST_TOO_LONG : ST_OK;
                        if (le == 16'h0) begin
                            do_accept = 1'b1;
                            next_attr = 1'b1;
                        end else if (last) begin
                            err_next   = ST_OVERRUN;
                            phase_next = PH_END;
                        end else begin
                            vrem_next  = le;
                            phase_next = PH_VALUE;
                        end
                    end
                end
            end
            PH_VALUE: begin
                voff              = clen_reg - vrem_reg;
                res.region        = RG_VALUE;
                res.region_offset = voff[8:0];
                res.attr_index    = anum_ext[3:0];
                res.attr_kind     = ctype_reg;
                res.attr_length   = clen_reg;
                if (ctype_reg == XMA_TYPE && !xseen_reg) begin
                    if (voff == 16'd1) begin
                        fam_next = b;
                    end else if (voff == 16'd2 || voff == 16'd3) begin
                        port_next = {port_reg[7:0], b};
                    end else if (voff >= 16'd4 && voff <= 16'd7) begin
                        ip_next = {ip_reg[23:0], b};
                    end
                end
                vdec      = vrem_reg - 16'd1;
                vrem_next = vdec;
                if (vdec == 16'h0) begin
                    if (perr_reg == ST_TOO_LONG) begin
                        err_next   = ST_TOO_LONG;
                        phase_next = PH_END;
                    end else begin
                        do_accept = 1'b1;
                        padt      = 2'd0 - clen_reg[1:0];
                        prem_next = padt;
                        if (padt == 2'd0) next_attr = 1'b1;
                        else              phase_next = PH_PAD;
                    end
                end else if (last) begin
                    err_next   = ST_OVERRUN;
                    phase_next = PH_END;
                end
            end
            PH_PAD: begin
                padt              = 2'd0 - clen_reg[1:0];
                res.region        = RG_PAD;
                res.region_offset = 9'(padt - prem_reg);
                res.attr_index    = (anum_ext == 32'd0) ? 4'd0 : anum_m1[3:0];
                res.attr_kind     = ctype_reg;
                res.attr_length   = clen_reg;
                pdec              = prem_reg - 2'd1;
                prem_next         = pdec;
                if (pdec == 2'd0) next_attr = 1'b1;
            end
            default: begin
            end
        endcase

        // attribute accepted: count it, settle the first XOR-MAPPED-ADDRESS
        if (do_accept) begin
            anum_next = AW'(anum_ext + 32'd1);
            if (ctype_next == XMA_TYPE && !xseen_reg) begin
                xseen_next = 1'b1;
                if (clen_next < 16'd8)          xst_next = XS_SHORT;
                else if (fam_next != FAMILY_V4) xst_next = XS_FAMILY;
                else                            xst_next = XS_FOUND;
            end
        end

        // padding may run past the limit; parsing just stops there
        if (phase_next == PH_PAD && after >= msg_end) phase_next = PH_END;
        if (next_attr) begin
            phase_next = (after >= msg_end) ? PH_END : PH_AHDR;
            hcnt_next  = 2'd0;
        end

        cnt_ext = 32'(anum_next);
        if (last) begin
            res.status       = err_next;
            res.attr_count   = cnt_ext[4:0];
            res.xaddr_status = xst_next;
            if (xst_next == XS_FOUND) begin
                res.mapped_ip   = ip_next ^ COOKIE;
                res.mapped_port = port_next ^ COOKIE[31:16];
            end
        end
    end

    // the last byte of a message returns the parser to its reset state
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last)) begin
            pos_reg   <= '0;
            mlen_reg  <= '0;
            phase_reg <= PH_HEADER;
            vrem_reg  <= '0;
            prem_reg  <= '0;
            anum_reg  <= '0;
            ctype_reg <= '0;
            clen_reg  <= '0;
            err_reg   <= ST_OK;
            perr_reg  <= ST_OK;
            xst_reg   <= XS_ABSENT;
            xseen_reg <= 1'b0;
            ip_reg    <= '0;
            port_reg  <= '0;
            hcnt_reg  <= '0;
            fam_reg   <= '0;
        end else if (step) begin
            pos_reg   <= pos_next;
            mlen_reg  <= mlen_next;
            phase_reg <= phase_next;
            vrem_reg  <= vrem_next;
            prem_reg  <= prem_next;
            anum_reg  <= anum_next;
            ctype_reg <= ctype_next;
            clen_reg  <= clen_next;
            err_reg   <= err_next;
            perr_reg  <= perr_next;
            xst_reg   <= xst_next;
            xseen_reg <= xseen_next;
            ip_reg    <= ip_next;
            port_reg  <= port_next;
            hcnt_reg  <= hcnt_next;
            fam_reg   <= fam_next;
        end
    end

endmodule

### hdl/smp_out_reg.sv
// ============================================================================
// smp_out_reg
// Result register: holds one tagged byte until the sink takes it.
// ============================================================================
module smp_out_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  smp_pkg::res_t res,
    output logic          adv,
    output logic          m_valid,
    input  logic          m_ready,
    output smp_pkg::res_t m_res
);
    import smp_pkg::*;

    logic vld_reg;
    logic vld_next;
    res_t res_reg;

    assign adv      = !vld_reg || m_ready;
    assign vld_next = adv ? load : vld_reg;
    assign m_valid  = vld_reg;
    assign m_res    = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && load) begin
            res_reg <= res;
        end
    end

endmodule

### hdl/stun_message_parser_top.sv
// ============================================================================
// stun_message_parser_top
// Datapath: input register, combinational parse step, result register, in that order.
// Throughput: one byte per cycle; the parse step is a single pass of counter and
// compare logic between the two registers, limited only by result backpressure.
// Reset: aresetn synchronous active low; clears both stages and the parser, which
// also returns to its reset state after each byte flagged last.
// ============================================================================
module stun_message_parser_top #(
    parameter int MAX_ATTRS       = 16,
    parameter int MAX_VALUE_BYTES = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    // byte input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    // tagged byte output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_byte_value,
    output logic [2:0]  m_region,
    output logic [8:0]  m_region_offset,
    output logic [3:0]  m_attr_index,
    output logic [15:0] m_attr_kind,
    output logic [15:0] m_attr_length,
    output logic        m_done_res,
    output logic [2:0]  m_status,
    output logic [4:0]  m_attr_count,
    output logic [1:0]  m_xaddr_status,
    output logic [31:0] m_mapped_ip,
    output logic [15:0] m_mapped_port
);
    import smp_pkg::*;

    item_t s_item;
    item_t in_item;
    res_t  core_res;
    res_t  m_res;
    logic  in_vld;
    logic  adv;
    logic  step;

    assign s_item.data_byte = s_data_byte;
    assign s_item.last_byte = s_last_byte;

    // parser advances when a byte is staged and the result slot is free
    assign step = adv && in_vld;

    smp_in_reg u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .adv     (adv),
        .in_vld  (in_vld),
        .in_item (in_item)
    );

    smp_core #(
        .MAX_ATTRS       (MAX_ATTRS),
        .MAX_VALUE_BYTES (MAX_VALUE_BYTES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item),
        .res     (core_res)
    );

    smp_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (step),
        .res     (core_res),
        .adv     (adv),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    assign m_byte_value    = m_res.byte_value;
    assign m_region        = m_res.region;
    assign m_region_offset = m_res.region_offset;
    assign m_attr_index    = m_res.attr_index;
    assign m_attr_kind     = m_res.attr_kind;
    assign m_attr_length   = m_res.attr_length;
    assign m_done_res      = m_res.done_res;
    assign m_status        = m_res.status;
    assign m_attr_count    = m_res.attr_count;
    assign m_xaddr_status  = m_res.xaddr_status;
    assign m_mapped_ip     = m_res.mapped_ip;
    assign m_mapped_port   = m_res.mapped_port;

    // input side stalls only behind a blocked result
    a_stall_cause : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without output backpressure");

    // summary fields are zero except on the closing byte
    a_summary_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_done_res) |->
            (m_status == ST_OK && m_attr_count == 5'd0 && m_xaddr_status == XS_FOUND))
        else $error("summary fields set on a non-final byte");

    // address fields only carry data when an address was found
    a_addr_gated : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (!m_done_res || m_xaddr_status != XS_FOUND)) |->
            (m_mapped_ip == 32'h0 && m_mapped_port == 16'h0))
        else $error("mapped address without a found attribute");

    // ignored bytes carry no position or attribute tags
    a_ignored_clean : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_region == RG_IGNORED) |->
            (m_region_offset == 9'd0 && m_attr_index == 4'd0 && m_attr_kind == 16'h0))
        else $error("ignored byte carries tags");

endmodule

### test/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for stun_message_parser_top. STUN messages are fed one
// byte per transaction. An in-bench model of the parser predicts every tagged
// byte, and each result transaction is checked field by field. A short table
// of directed bytes comes first, then generated messages: clean, truncated,
// trailing junk, bad length, unpadded limit, noise, attribute floods and an
// oversized value.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import smp_pkg::*;

    localparam int MAX_ATTRS       = 16;
    localparam int MAX_VALUE_BYTES = 512;
    localparam int MIX_BYTES       = 500;        // byte budget of the generated messages, the oversized one excluded
    localparam int DRAIN_CYCLES    = 20;         // quiet cycles after the last result
    // Timeout: well above the slowest legal run, all bytes at the worst receiver duty
    // plus sender gaps.
    localparam int CYCLE_LIMIT     = 100_000;

    // parser phases of the in-bench model
    typedef enum logic [2:0] {PH_HEADER, PH_AHDR, PH_VALUE, PH_PAD, PH_END} parse_phase_e;

    // shapes of generated messages
    typedef enum int {
        MK_GOOD, MK_CUT, MK_TRAIL, MK_BADLEN, MK_NOPAD, MK_NOISE, MK_MANY, MK_LONG
    } msg_kind_e;

    // receiver stall patterns
    typedef enum int {RX_FREE, RX_SPARSE, RX_PATTERN, RX_COIN} rx_mode_e;

    // one row of the directed table; want is used only when typed is set
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         typed;
        res_t       want;
    } stim_row_t;

    // directed header: extreme type, length 4, proper cookie, mixed transaction id
    localparam logic [7:0] DIR_HDR [0:19] = '{
        8'hFF, 8'hFF, 8'h00, 8'h04, 8'h21, 8'h12, 8'hA4, 8'h42,
        8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE,
        8'h13, 8'hC4, 8'h9B, 8'h66
    };

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_byte_value;
    logic [2:0]  m_region;
    logic [8:0]  m_region_offset;
    logic [3:0]  m_attr_index;
    logic [15:0] m_attr_kind;
    logic [15:0] m_attr_length;
    logic        m_done_res;
    logic [2:0]  m_status;
    logic [4:0]  m_attr_count;
    logic [1:0]  m_xaddr_status;
    logic [31:0] m_mapped_ip;
    logic [15:0] m_mapped_port;

    stun_message_parser_top #(
        .MAX_ATTRS       (MAX_ATTRS),
        .MAX_VALUE_BYTES (MAX_VALUE_BYTES)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_byte_value    (m_byte_value),
        .m_region        (m_region),
        .m_region_offset (m_region_offset),
        .m_attr_index    (m_attr_index),
        .m_attr_kind     (m_attr_kind),
        .m_attr_length   (m_attr_length),
        .m_done_res      (m_done_res),
        .m_status        (m_status),
        .m_attr_count    (m_attr_count),
        .m_xaddr_status  (m_xaddr_status),
        .m_mapped_ip     (m_mapped_ip),
        .m_mapped_port   (m_mapped_port)
    );

    // ------------------------------------------------------------------------
    // Parser model state
    // ------------------------------------------------------------------------
    logic [16:0]  pk_pos;
    logic [15:0]  pk_msg_len;
    parse_phase_e pk_phase;
    logic [15:0]  pk_val_rem;
    logic [1:0]   pk_pad_rem;
    logic [4:0]   pk_attr_num;
    logic [15:0]  pk_type;
    logic [15:0]  pk_len;
    logic [2:0]   pk_err;
    logic [2:0]   pk_pend;
    logic [1:0]   pk_xstate;
    logic         pk_xseen;
    logic [31:0]  pk_ip;
    logic [15:0]  pk_port;
    logic [2:0]   pk_hdr_cnt;
    logic [7:0]   pk_family;

    res_t         tags_due[$];       // predicted tags, oldest first
    logic [7:0]   msg_q[$];          // bytes of the message being sent
    int           err_cnt = 0;
    int           burst_left = 0;
    int           cycle_cnt = 0;

    function automatic void parser_reset();
        pk_pos = '0; pk_msg_len = '0; pk_phase = PH_HEADER;
        pk_val_rem = '0; pk_pad_rem = '0; pk_attr_num = '0;
        pk_type = '0; pk_len = '0; pk_err = ST_OK; pk_pend = ST_OK;
        pk_xstate = XS_ABSENT; pk_xseen = 1'b0; pk_ip = '0; pk_port = '0;
        pk_hdr_cnt = '0; pk_family = '0;
    endfunction

    function automatic void abort_parse(input logic [2:0] code);
        pk_err   = code;
        pk_phase = PH_END;
    endfunction

    // Counts the attribute; the first XOR-MAPPED-ADDRESS decides the address status.
    function automatic void accept_attr();
        pk_attr_num++;
        if (pk_type == XMA_TYPE && !pk_xseen) begin
            pk_xseen = 1'b1;
            if (pk_len < 16'd8)
                pk_xstate = XS_SHORT;
            else if (pk_family != FAMILY_V4)
                pk_xstate = XS_FAMILY;
            else
                pk_xstate = XS_FOUND;
        end
    endfunction

    // Tags one byte and advances the model, mirroring the parser's single step.
    function automatic res_t tag_byte(input logic [7:0] b, input logic last);
        res_t        r;
        logic [31:0] pos;
        logic [31:0] after;
        logic [31:0] msg_end;
        logic [15:0] voff;
        logic [1:0]  pad_off;
        logic [4:0]  prev_idx;
        bit          next_attr;
        r         = '0;
        next_attr = 1'b0;
        pos       = 32'(pk_pos);
        after     = pos + 32'd1;
        msg_end   = 32'(HDR_BYTES) + 32'(pk_msg_len);
        r.byte_value = b;
        r.region     = RG_IGNORED;

        case (pk_phase)
            PH_HEADER: begin
                if (pos < 32'd2) begin
                    r.region = RG_TYPE;   r.region_offset = 9'(pos);
                end else if (pos < 32'd4) begin
                    r.region = RG_LENGTH; r.region_offset = 9'(pos - 32'd2);
                end else if (pos < 32'd8) begin
                    r.region = RG_COOKIE; r.region_offset = 9'(pos - 32'd4);
                end else begin
                    r.region = RG_TID;    r.region_offset = 9'(pos - 32'd8);
                end
                if (pos == 32'd2) pk_msg_len = {b, 8'h00};
                if (pos == 32'd3) pk_msg_len[7:0] = b;
                if (pos >= 32'd19) begin
                    pk_phase   = (pk_msg_len == 16'd0) ? PH_END : PH_AHDR;
                    pk_hdr_cnt = '0;
                end else if (last) begin
                    abort_parse(ST_SHORT_HDR);
                end
            end
            PH_AHDR: begin
                r.region        = RG_AHDR;
                r.region_offset = {7'd0, pk_hdr_cnt[1:0]};
                r.attr_index    = pk_attr_num[3:0];
                if (pk_hdr_cnt == 3'd0) begin
                    pk_pend = (pk_attr_num >= MAX_ATTRS) ? ST_TOO_MANY : ST_OK;
                    pk_type = '0;
                    pk_len  = '0;
                end
                if (pk_hdr_cnt < 3'd2)
                    pk_type = {pk_type[7:0], b};
                else
                    pk_len = {pk_len[7:0], b};
                pk_hdr_cnt++;
                if (pk_hdr_cnt < 3'd4) begin
                    if (last || after >= msg_end) abort_parse(ST_CUT_AHDR);
                end else begin
                    pk_hdr_cnt = '0;
                    if (pk_pend == ST_TOO_MANY) begin
                        abort_parse(ST_TOO_MANY);
                    end else if (after > msg_end || 32'(pk_len) > msg_end - after) begin
                        abort_parse(ST_OVERRUN);
                    end else begin
                        pk_pend = (pk_len > MAX_VALUE_BYTES) ? ST_TOO_LONG : ST_OK;
                        if (pk_len == 16'd0) begin
                            accept_attr();
                            next_attr = 1'b1;
                        end else if (last) begin
                            abort_parse(ST_OVERRUN);
                        end else begin
                            pk_val_rem = pk_len;
                            pk_phase   = PH_VALUE;
                        end
                    end
                end
            end
            PH_VALUE: begin
                voff            = pk_len - pk_val_rem;
                r.region        = RG_VALUE;
                r.region_offset = voff[8:0];
                r.attr_index    = pk_attr_num[3:0];
                r.attr_kind     = pk_type;
                r.attr_length   = pk_len;
                // only the first XOR-MAPPED-ADDRESS is collected
                if (pk_type == XMA_TYPE && !pk_xseen) begin
                    if (voff == 16'd1)
                        pk_family = b;
                    else if (voff == 16'd2 || voff == 16'd3)
                        pk_port = {pk_port[7:0], b};
                    else if (voff >= 16'd4 && voff <= 16'd7)
                        pk_ip = {pk_ip[23:0], b};
                end
                pk_val_rem = pk_val_rem - 16'd1;
                if (pk_val_rem == 16'd0) begin
                    if (pk_pend == ST_TOO_LONG) begin
                        abort_parse(ST_TOO_LONG);
                    end else begin
                        accept_attr();
                        pk_pad_rem = 2'd0 - pk_len[1:0];
                        if (pk_pad_rem == 2'd0)
                            next_attr = 1'b1;
                        else
                            pk_phase = PH_PAD;
                    end
                end else if (last) begin
                    abort_parse(ST_OVERRUN);
                end
            end
            PH_PAD: begin
                pad_off         = (2'd0 - pk_len[1:0]) - pk_pad_rem;
                prev_idx        = pk_attr_num - 5'd1;
                r.region        = RG_PAD;
                r.region_offset = {7'd0, pad_off};
                r.attr_index    = (pk_attr_num == 5'd0) ? 4'd0 : prev_idx[3:0];
                r.attr_kind     = pk_type;
                r.attr_length   = pk_len;
                pk_pad_rem      = pk_pad_rem - 2'd1;
                if (pk_pad_rem == 2'd0) next_attr = 1'b1;
            end
            default: begin
            end
        endcase

        // padding that runs past the limit is ignored
        if (pk_phase == PH_PAD && after >= msg_end) pk_phase = PH_END;
        if (next_attr) begin
            pk_phase   = (after >= msg_end) ? PH_END : PH_AHDR;
            pk_hdr_cnt = '0;
        end
        pk_pos = (pos >= 32'(POS_MAX)) ? POS_MAX : after[16:0];

        r.done_res = last;
        if (last) begin
            r.status       = pk_err;
            r.attr_count   = pk_attr_num;
            r.xaddr_status = pk_xstate;
            if (pk_xstate == XS_FOUND) begin
                r.mapped_ip   = pk_ip ^ COOKIE;
                r.mapped_port = pk_port ^ COOKIE[31:16];
            end
            parser_reset();
        end
        return r;
    endfunction

    // Typed expectation for a final byte that ends the parse early.
    function automatic res_t done_result(input logic [7:0] b, input logic [2:0] rg,
                                         input logic [8:0] off, input logic [2:0] st);
        res_t r;
        r               = '0;
        r.byte_value    = b;
        r.region        = rg;
        r.region_offset = off;
        r.done_res      = 1'b1;
        r.status        = st;
        r.xaddr_status  = XS_ABSENT;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Reset asserted from the start, released on a falling edge, never asserted again.
    initial begin
        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Sender: bursts of random length with random gaps. Called at a falling
    // edge, returns at the falling edge after the transaction is accepted.
    // valid is only lowered when a gap follows, so it never toggles in one step.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input bit typed, input res_t want);
        int   gap;
        res_t pred;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256)
                                                     : $urandom_range(1, 16);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // accepted at this edge: the model advances on every byte, the directed
        // rows with a typed result replace the prediction
        pred = tag_byte(b, last);
        tags_due.push_back(typed ? want : pred);
        @(negedge aclk);
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_q.size(); i++)
            send_byte(msg_q[i], (i == msg_q.size() - 1), 1'b0, '0);
    endtask

    // Builds one message into msg_q. Attributes are well formed; the kind picks
    // how the framing is then broken, if at all.
    task automatic build_stun_message(input msg_kind_e kind);
        logic [7:0]  body[$];
        logic [15:0] atype;
        logic [15:0] decl_len;
        logic [31:0] word;
        int          n_attr;
        int          alen;
        int          last_pad;
        int          full_len;
        int          keep_len;
        body     = {};
        msg_q    = {};
        last_pad = 0;
        if (kind == MK_NOISE) begin
            repeat ($urandom_range(1, 30)) msg_q.push_back(8'($urandom));
            return;
        end

        if (kind == MK_MANY)
            n_attr = $urandom_range(15, 17);        // around the attribute limit
        else if (kind == MK_LONG)
            n_attr = 2;
        else
            n_attr = $urandom_range(0, 4);

        for (int i = 0; i < n_attr; i++) begin
            word = $urandom;
            if (kind == MK_MANY) begin
                // leading address, then a flood of tiny attributes
                atype = (i == 0) ? XMA_TYPE : word[15:0];
                alen  = (i == 0) ? 8 : (word[16] ? 0 : 4);
            end else if (kind == MK_LONG && i == 1) begin
                // straddles the value size limit
                atype = word[15:0];
                alen  = $urandom_range(MAX_VALUE_BYTES - 8, MAX_VALUE_BYTES + 24);
            end else begin
                case (word[18:16])
                    3'd0, 3'd1, 3'd2: begin
                        atype = XMA_TYPE;
                        alen  = (word[19] && word[20]) ? $urandom_range(0, 12) : 8;
                    end
                    3'd3: begin
                        atype = word[15:0];
                        alen  = 0;
                    end
                    default: begin
                        atype = word[15:0];
                        alen  = $urandom_range(1, 12);
                    end
                endcase
            end
            body.push_back(atype[15:8]);
            body.push_back(atype[7:0]);
            body.push_back(8'(alen >> 8));
            body.push_back(8'(alen));
            // family byte is usually IPv4, sometimes anything
            for (int j = 0; j < alen; j++)
                body.push_back((atype == XMA_TYPE && j == 1 && word[22:21] != 2'b00)
                               ? FAMILY_V4 : 8'($urandom));
            last_pad = (4 - alen % 4) % 4;
            repeat (last_pad) body.push_back(8'($urandom));
        end

        full_len = body.size();
        decl_len = 16'(full_len);
        word     = $urandom;
        case (kind)
            MK_BADLEN: decl_len = word[0] ? word[31:16]
                                          : 16'(full_len + int'($urandom_range(0, 16)) - 8);
            MK_NOPAD:  decl_len = 16'(full_len - last_pad);   // limit ends before padding
            default: begin
            end
        endcase

        // header: type, length, cookie (mostly right), transaction id
        word = $urandom;
        msg_q.push_back(word[15:8]);
        msg_q.push_back(word[7:0]);
        msg_q.push_back(decl_len[15:8]);
        msg_q.push_back(decl_len[7:0]);
        word = ($urandom_range(0, 7) != 0) ? COOKIE : $urandom;
        msg_q.push_back(word[31:24]);
        msg_q.push_back(word[23:16]);
        msg_q.push_back(word[15:8]);
        msg_q.push_back(word[7:0]);
        repeat (12) msg_q.push_back(8'($urandom));
        foreach (body[k]) msg_q.push_back(body[k]);

        // stream shaping
        if (kind == MK_CUT ||
            ((kind == MK_BADLEN || kind == MK_LONG) && $urandom_range(0, 1) == 0)) begin
            keep_len = $urandom_range(1, msg_q.size());
            while (msg_q.size() > keep_len) void'(msg_q.pop_back());
        end
        if (kind == MK_TRAIL)
            repeat ($urandom_range(1, 8)) msg_q.push_back(8'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        stim_row_t dir_rows[$];
        int        mixed_bytes;
        int        pick;
        msg_kind_e kind;
        s_valid     = 1'b0;
        s_data_byte = 8'h00;
        s_last_byte = 1'b0;
        mixed_bytes = 0;
        parser_reset();

        // Directed table. Single-byte messages hit the short header check with
        // both byte extremes; then a header declaring 4 bytes of attributes,
        // whose attribute header is cut by the last flag after two bytes.
        dir_rows.push_back('{8'hFF, 1'b1, 1'b1,
                             done_result(8'hFF, RG_TYPE, 9'd0, ST_SHORT_HDR)});
        dir_rows.push_back('{8'h00, 1'b1, 1'b1,
                             done_result(8'h00, RG_TYPE, 9'd0, ST_SHORT_HDR)});
        for (int i = 0; i < 20; i++)
            dir_rows.push_back('{DIR_HDR[i], 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'h20, 1'b1, 1'b1,
                             done_result(8'h20, RG_AHDR, 9'd1, ST_CUT_AHDR)});

        @(posedge aresetn);
        @(negedge aclk);
        foreach (dir_rows[i])
            send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
                      dir_rows[i].want);

        // one message of every shape first, the oversized value included
        for (int k = MK_GOOD; k <= MK_LONG; k++) begin
            build_stun_message(msg_kind_e'(k));
            send_message();
            if (k != MK_LONG) mixed_bytes += msg_q.size();
        end

        // weighted mix, mostly well-framed messages with random content
        while (mixed_bytes < MIX_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      kind = MK_GOOD;
            else if (pick < 50) kind = MK_CUT;
            else if (pick < 60) kind = MK_TRAIL;
            else if (pick < 75) kind = MK_BADLEN;
            else if (pick < 85) kind = MK_NOPAD;
            else if (pick < 95) kind = MK_NOISE;
            else                kind = MK_MANY;
            build_stun_message(kind);
            send_message();
            mixed_bytes += msg_q.size();
        end

        s_valid <= 1'b0;
        while (tags_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern re-chosen at random intervals.
    // Free flow, sparse stalls, a rotating mask (never all zero), or a coin flip.
    // ------------------------------------------------------------------------
    initial begin
        int         hold;
        rx_mode_e   mode;
        logic [7:0] mask;
        hold    = 0;
        mode    = RX_FREE;
        mask    = 8'hFF;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold == 0) begin
                mode = rx_mode_e'($urandom_range(0, 3));
                hold = $urandom_range(8, 200);
                mask = 8'($urandom) | 8'h01;
            end
            hold--;
            case (mode)
                RX_FREE:    m_ready <= 1'b1;
                RX_SPARSE:  m_ready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: begin
                    m_ready <= mask[0];
                    mask = {mask[0], mask[7:1]};
                end
                default:    m_ready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result check: every accepted result transaction against the oldest tag.
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (tags_due.size() == 0) begin
                $error("result transaction with none expected, byte 0x%0h", m_byte_value);
                err_cnt++;
            end else begin
                want = tags_due.pop_front();
                check_field("byte_value",    32'(want.byte_value),    32'(m_byte_value));
                check_field("region",        32'(want.region),        32'(m_region));
                check_field("region_offset", 32'(want.region_offset), 32'(m_region_offset));
                check_field("attr_index",    32'(want.attr_index),    32'(m_attr_index));
                check_field("attr_kind",     32'(want.attr_kind),     32'(m_attr_kind));
                check_field("attr_length",   32'(want.attr_length),   32'(m_attr_length));
                check_field("done_res",      32'(want.done_res),      32'(m_done_res));
                check_field("status",        32'(want.status),        32'(m_status));
                check_field("attr_count",    32'(want.attr_count),    32'(m_attr_count));
                check_field("xaddr_status",  32'(want.xaddr_status),  32'(m_xaddr_status));
                check_field("mapped_ip",     want.mapped_ip,          m_mapped_ip);
                check_field("mapped_port",   32'(want.mapped_port),   32'(m_mapped_port));
            end
        end
    end

    // Watchdog: a stuck handshake ends the run as a failure.
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule
